[hdl/ops_pkg.sv]
`timescale 1ns / 1ps
package ops_pkg;

   localparam int unsigned FULL_TURN    = 360;
   localparam int unsigned QUARTER_TURN = 90;
   localparam int unsigned TRIG_ONE     = 1000;
   localparam int unsigned PCT_DIV      = 100;
   localparam int unsigned RADIUS_SPLIT = 10;

   localparam int unsigned STAGES = 6;

   // Register indexes on the configuration port.
   localparam logic [7:0] CSR_X_SCALE = 8'd0;
   localparam logic [7:0] CSR_Y_SCALE = 8'd1;

   // Quarter-wave sine table, scaled to 1000.
   localparam logic [9:0] SINE_TABLE [0:90] = '{
      10'd0,   10'd17,  10'd34,  10'd52,  10'd69,  10'd87,  10'd104, 10'd121, 10'd139, 10'd156,
      10'd173, 10'd190, 10'd207, 10'd224, 10'd241, 10'd258, 10'd275, 10'd292, 10'd309, 10'd325,
      10'd342, 10'd358, 10'd374, 10'd390, 10'd406, 10'd422, 10'd438, 10'd453, 10'd469, 10'd484,
      10'd500, 10'd515, 10'd529, 10'd544, 10'd559, 10'd573, 10'd587, 10'd601, 10'd615, 10'd629,
      10'd642, 10'd656, 10'd669, 10'd681, 10'd694, 10'd707, 10'd719, 10'd731, 10'd743, 10'd754,
      10'd766, 10'd777, 10'd788, 10'd798, 10'd809, 10'd819, 10'd829, 10'd838, 10'd848, 10'd857,
      10'd866, 10'd874, 10'd882, 10'd891, 10'd898, 10'd906, 10'd913, 10'd920, 10'd927, 10'd933,
      10'd939, 10'd945, 10'd951, 10'd956, 10'd961, 10'd965, 10'd970, 10'd974, 10'd978, 10'd981,
      10'd984, 10'd987, 10'd990, 10'd992, 10'd994, 10'd996, 10'd997, 10'd998, 10'd999, 10'd999,
      10'd1000
   };

   // Angle folded into the first quadrant: table index and sign of the sine.
   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } fold_type;

   // Advance strobes for the stages held inside an axis lane.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipe_ctl_type;

   // Fold an angle already reduced below 360 degrees.
   function automatic fold_type fold_angle(input logic [8:0] a);
      fold_type   f;
      logic [8:0] t;
      if (a < 9'(QUARTER_TURN)) begin
         t     = a;
         f.neg = 1'b0;
      end else if (a < 9'(2 * QUARTER_TURN)) begin
         t     = 9'(2 * QUARTER_TURN) - a;
         f.neg = 1'b0;
      end else if (a < 9'(3 * QUARTER_TURN)) begin
         t     = a - 9'(2 * QUARTER_TURN);
         f.neg = 1'b1;
      end else begin
         t     = 9'(FULL_TURN) - a;
         f.neg = 1'b1;
      end
      f.idx = t[6:0];
      return f;
   endfunction

   // Floor of x / 100: low reciprocal estimate, then one correction step.
   function automatic logic [10:0] div_pct(input logic [16:0] x);
      logic [26:0] p;
      logic [10:0] q;
      logic [16:0] r;
      p = 27'(x) * 27'(655);
      q = p[26:16];
      r = x - 17'(17'(q) * 17'(PCT_DIV));
      if (r >= 17'(PCT_DIV)) begin
         q = q + 11'd1;
      end
      return q;
   endfunction

   // Floor of y / 1000 for products of units and the table value.
   function automatic logic [4:0] div_trig(input logic [13:0] y);
      logic [20:0] p;
      logic [4:0]  q;
      logic [13:0] r;
      p = 21'(y) * 21'(65);
      q = p[20:16];
      r = y - 14'(14'(q) * 14'(TRIG_ONE));
      if (r >= 14'(TRIG_ONE)) begin
         q = q + 5'd1;
      end
      return q;
   endfunction

endpackage

[hdl/ops_axis.sv]
`timescale 1ns / 1ps
module ops_axis
   import ops_pkg::*;
(
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  fold_type     fold,
   input  logic [4:0]   tens,
   input  logic [3:0]   units,
   input  logic [15:0]  center,
   input  logic [7:0]   pct,
   output logic [15:0]  pos
);

   // The sign rides along; all arithmetic works on magnitudes, which gives
   // truncation toward zero for negative offsets.
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [15:0] ctr1_ff, ctr2_ff, ctr3_ff, ctr4_ff;
   logic [4:0]  tens1_ff;
   logic [3:0]  units1_ff;
   logic [9:0]  mag_ff;
   logic [14:0] prod_t_ff, prod_t_in;
   logic [13:0] prod_u_ff, prod_u_in;
   logic [8:0]  offm_ff, offm_in;
   logic [16:0] scl_ff, scl_in;
   logic [9:0]  quot;
   logic [15:0] pos_ff, pos_in;

   assign prod_t_in = 15'(tens1_ff) * 15'(mag_ff);
   assign prod_u_in = 14'(units1_ff) * 14'(mag_ff);
   assign offm_in   = 9'(div_pct(17'(prod_t_ff))) + 9'(div_trig(prod_u_ff));
   assign scl_in    = 17'(offm_ff) * 17'(pct);
   assign quot      = 10'(div_pct(scl_ff));
   assign pos_in    = neg4_ff ? (ctr4_ff - 16'(quot)) : (ctr4_ff + 16'(quot));

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         mag_ff    <= SINE_TABLE[fold.idx];
         neg1_ff   <= fold.neg;
         tens1_ff  <= tens;
         units1_ff <= units;
         ctr1_ff   <= center;
      end
      if (ctl.s2) begin
         prod_t_ff <= prod_t_in;
         prod_u_ff <= prod_u_in;
         neg2_ff   <= neg1_ff;
         ctr2_ff   <= ctr1_ff;
      end
      if (ctl.s3) begin
         offm_ff <= offm_in;
         neg3_ff <= neg2_ff;
         ctr3_ff <= ctr2_ff;
      end
      if (ctl.s4) begin
         scl_ff  <= scl_in;
         neg4_ff <= neg3_ff;
         ctr4_ff <= ctr3_ff;
      end
      if (ctl.s5) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

[hdl/orbital_position_from_sine_table.sv]
`timescale 1ns / 1ps
// Each accepted request item passes through every pipeline stage to its response item.
// Throughput: one item per cycle while rsp_tready holds; every stage holds
// one item and moves on when the stage after it is empty or moving, so
// bubbles close up on a stall. Reset (synchronous, active high) empties
// the pipeline and sets both scale registers to 100.
module orbital_position_from_sine_table
   import ops_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: center_x[15:0], center_y[31:16], angle[40:32],
   // radius[48:41], zero fill [55:49].
   input  logic [55:0] req_tdata,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: pos_x[15:0], pos_y[31:16].
   output logic [31:0] rsp_tdata,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Scale registers. A write to an index other than the two registers is
   // taken and dropped.
   logic [7:0] x_scale_ff, y_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= 8'(PCT_DIV);
         y_scale_ff <= 8'(PCT_DIV);
      end else if (csr_valid) begin
         if (csr_index == CSR_X_SCALE) begin
            x_scale_ff <= csr_data;
         end else if (csr_index == CSR_Y_SCALE) begin
            y_scale_ff <= csr_data;
         end
      end
   end

   // Stage control: one valid bit per stage, and an advance strobe that
   // lets a stage load whenever it is empty or its item moves on.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   // First stage: reduce the angle modulo 360, form the cosine angle as the
   // angle plus 90 reduced again, fold both into one quadrant, and split
   // the radius into tens and units.
   logic [15:0] in_cx, in_cy;
   logic [8:0]  in_ang, in_rad_ext;
   logic [7:0]  in_rad;
   logic [8:0]  ang_red, cos_sum, cos_red;
   logic [15:0] tens_prod;
   logic [4:0]  tens_in;
   logic [3:0]  units_in;

   assign in_cx      = req_tdata[15:0];
   assign in_cy      = req_tdata[31:16];
   assign in_ang     = req_tdata[40:32];
   assign in_rad     = req_tdata[48:41];
   assign in_rad_ext = 9'(in_rad);

   assign ang_red   = (in_ang >= 9'(FULL_TURN)) ? (in_ang - 9'(FULL_TURN)) : in_ang;
   assign cos_sum   = ang_red + 9'(QUARTER_TURN);
   assign cos_red   = (cos_sum >= 9'(FULL_TURN)) ? (cos_sum - 9'(FULL_TURN)) : cos_sum;
   // Radius over ten through a reciprocal that is exact for eight-bit radii.
   assign tens_prod = 16'(in_rad) * 16'(205);
   assign tens_in   = tens_prod[15:11];
   assign units_in  = 4'(in_rad_ext - 9'(9'(tens_in) * 9'(RADIUS_SPLIT)));

   fold_type    fold_x_ff, fold_y_ff;
   logic [4:0]  tens_ff;
   logic [3:0]  units_ff;
   logic [15:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         fold_x_ff <= fold_angle(ang_red);
         fold_y_ff <= fold_angle(cos_red);
         tens_ff   <= tens_in;
         units_ff  <= units_in;
         cx_ff     <= in_cx;
         cy_ff     <= in_cy;
      end
   end

   // Remaining five stages run in one lane per axis: table lookup, the two
   // radius products, division and sum, percent scale, final division and
   // the wrapping add to the centre.
   pipe_ctl_type ctl;

   assign ctl.s1 = adv[1];
   assign ctl.s2 = adv[2];
   assign ctl.s3 = adv[3];
   assign ctl.s4 = adv[4];
   assign ctl.s5 = adv[5];

   logic [15:0] pos_x, pos_y;

   ops_axis u_axis_x (
      .clock  (clock),
      .ctl    (ctl),
      .fold   (fold_x_ff),
      .tens   (tens_ff),
      .units  (units_ff),
      .center (cx_ff),
      .pct    (x_scale_ff),
      .pos    (pos_x)
   );

   ops_axis u_axis_y (
      .clock  (clock),
      .ctl    (ctl),
      .fold   (fold_y_ff),
      .tens   (tens_ff),
      .units  (units_ff),
      .center (cy_ff),
      .pct    (y_scale_ff),
      .pos    (pos_y)
   );

   assign rsp_tdata = {pos_y, pos_x};

`ifndef ASSERT_OFF
   // The request side is held off only when every stage holds an item.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("request stalled while a stage is empty");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A write to the horizontal scale register lands in the next cycle.
   a_x_scale_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == CSR_X_SCALE))
      |=> (x_scale_ff == $past(csr_data)))
      else $error("horizontal scale write lost");
`endif

endmodule
